// File: rtl/e2q_pkg.sv
`timescale 1ns / 1ps

package e2q_pkg;

  localparam int TrigStages = 16;
  localparam int AtanLen = 24;
  // Stage counts beyond the arctangent table run the whole table; zero or less runs none.
  localparam int CellCount = (TrigStages > AtanLen) ? AtanLen :
                             ((TrigStages < 0) ? 0 : TrigStages);
  localparam int StageW = 5;
  localparam int LaneCount = 3;

  localparam int LaneSum  = 0;
  localparam int LaneDiff = 1;
  localparam int LaneMid  = 2;

  // Rotator gain compensation, 0.60725 in Q30.
  localparam logic signed [31:0] CordicX0 = 32'sd652032874;

  typedef logic signed [31:0] q30_t;

  typedef struct packed {
    q30_t x;
    q30_t y;
    q30_t z;
  } rot_t;

  typedef struct packed {
    logic                       valid;
    logic [LaneCount-1:0]       flip;
    rot_t [LaneCount-1:0]       rot;
  } row_t;

  // Arctangent of 2^-i in binary angle units, 2^32 units per full turn.
  function automatic q30_t atan_units(input logic [StageW-1:0] idx);
    q30_t r;
    case (idx)
      5'd0:    r = 32'sh20000000;
      5'd1:    r = 32'sh12E4051E;
      5'd2:    r = 32'sh09FB385B;
      5'd3:    r = 32'sh051111D4;
      5'd4:    r = 32'sh028B0D43;
      5'd5:    r = 32'sh0145D7E1;
      5'd6:    r = 32'sh00A2F61E;
      5'd7:    r = 32'sh00517C55;
      5'd8:    r = 32'sh0028BE53;
      5'd9:    r = 32'sh00145F2F;
      5'd10:   r = 32'sh000A2F98;
      5'd11:   r = 32'sh000517CC;
      5'd12:   r = 32'sh00028BE6;
      5'd13:   r = 32'sh000145F3;
      5'd14:   r = 32'sh0000A2F9;
      5'd15:   r = 32'sh0000517C;
      5'd16:   r = 32'sh000028BE;
      5'd17:   r = 32'sh0000145F;
      5'd18:   r = 32'sh00000A2F;
      5'd19:   r = 32'sh00000517;
      5'd20:   r = 32'sh0000028B;
      5'd21:   r = 32'sh00000145;
      5'd22:   r = 32'sh000000A2;
      5'd23:   r = 32'sh00000051;
      default: r = 32'sh00000000;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/euler_to_quaternion.sv
// Path: input row, rotator cells, sign fix, product, rounding and output registers to out_valid.
// Throughput: one word per cycle unless stalled; each rotator cell steps all three angles once.
// A two-entry output buffer lets a new word enter while a finished one waits to be taken.
// Reset (rst, synchronous) clears all valid flags and the buffer; data registers are not reset.
`timescale 1ns / 1ps

module euler_to_quaternion (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  angle_first,
  input  logic signed [15:0]  angle_second,
  input  logic signed [15:0]  angle_third,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  q_w,
  output logic signed [15:0]  q_x,
  output logic signed [15:0]  q_y,
  output logic signed [15:0]  q_z
);

  localparam int N = e2q_pkg::CellCount;
  localparam int L = e2q_pkg::LaneCount;

  logic advance;
  logic skid_full;
  logic take;

  e2q_pkg::row_t row_prep;
  e2q_pkg::row_t rows [0:N];

  e2q_pkg::q30_t cosv [0:L-1];
  e2q_pkg::q30_t sinv [0:L-1];
  logic          v_fix;
  logic          v_prod;
  logic          v_rnd;

  logic signed [15:0] r_w, r_x, r_y, r_z;
  logic signed [15:0] skid_w, skid_x, skid_y, skid_z;

  assign advance  = !skid_full;
  assign in_stall = skid_full;
  assign take     = out_valid && !out_stall;

  // The 17-bit half angles are binary angles of 2^17 units per turn; widen to 32 bits and
  // fold the left half plane onto the right, remembering to negate the results.
  always_comb begin
    logic signed [16:0] half [0:L-1];
    logic        [31:0] ang;
    logic               flip;
    half[e2q_pkg::LaneSum]  = {angle_first[15], angle_first} + {angle_third[15], angle_third};
    half[e2q_pkg::LaneDiff] = {angle_first[15], angle_first} - {angle_third[15], angle_third};
    half[e2q_pkg::LaneMid]  = {angle_second[15], angle_second};
    row_prep.valid = in_valid;
    for (int l = 0; l < L; l++) begin
      ang  = {half[l], 15'b0};
      flip = ang[31] ^ ang[30];
      row_prep.flip[l]  = flip;
      row_prep.rot[l].x = e2q_pkg::CordicX0;
      row_prep.rot[l].y = '0;
      row_prep.rot[l].z = {ang[31] ^ flip, ang[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows[0].valid <= 1'b0;
    end else if (advance) begin
      rows[0] <= row_prep;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    e2q_cordic_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (advance),
      .stage   (e2q_pkg::StageW'(k)),
      .row_in  (rows[k]),
      .row_out (rows[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_fix  <= 1'b0;
      v_prod <= 1'b0;
      v_rnd  <= 1'b0;
    end else if (advance) begin
      v_fix  <= rows[N].valid;
      v_prod <= v_fix;
      v_rnd  <= v_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int l = 0; l < L; l++) begin
        cosv[l] <= rows[N].flip[l] ? -rows[N].rot[l].x : rows[N].rot[l].x;
        sinv[l] <= rows[N].flip[l] ? -rows[N].rot[l].y : rows[N].rot[l].y;
      end
    end
  end

  e2q_prod u_prod_w (
    .clk (clk), .en (advance),
    .a (cosv[e2q_pkg::LaneSum]), .b (cosv[e2q_pkg::LaneMid]), .r (r_w)
  );
  e2q_prod u_prod_x (
    .clk (clk), .en (advance),
    .a (cosv[e2q_pkg::LaneDiff]), .b (sinv[e2q_pkg::LaneMid]), .r (r_x)
  );
  e2q_prod u_prod_y (
    .clk (clk), .en (advance),
    .a (sinv[e2q_pkg::LaneDiff]), .b (sinv[e2q_pkg::LaneMid]), .r (r_y)
  );
  e2q_prod u_prod_z (
    .clk (clk), .en (advance),
    .a (sinv[e2q_pkg::LaneSum]), .b (cosv[e2q_pkg::LaneMid]), .r (r_z)
  );

  // A word leaving the pipeline goes to the output register when it is free,
  // otherwise into the skid entry, which then holds the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_full) begin
        out_valid <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        out_valid <= v_rnd;
      end
    end else if (v_rnd && advance) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_full) begin
        q_w <= skid_w;
        q_x <= skid_x;
        q_y <= skid_y;
        q_z <= skid_z;
      end else begin
        q_w <= r_w;
        q_x <= r_x;
        q_y <= r_y;
        q_z <= r_z;
      end
    end else if (v_rnd && advance) begin
      skid_w <= r_w;
      skid_x <= r_x;
      skid_y <= r_y;
      skid_z <= r_z;
    end
  end

  a_skid_needs_out : assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid)
    else $error("skid entry full while output register empty");

  a_spill_on_stall : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && !skid_full && v_rnd) |=> skid_full)
    else $error("finished word not captured in skid entry");

  a_skid_drains : assert property (@(posedge clk) disable iff (rst)
    (take && skid_full) |=> (out_valid && !skid_full))
    else $error("skid entry did not move to output register");

  a_hold_when_full : assert property (@(posedge clk) disable iff (rst)
    skid_full |=> $stable(v_rnd) && $stable(r_w))
    else $error("pipeline moved while skid entry full");

endmodule

// File: rtl/e2q_cordic_cell.sv
`timescale 1ns / 1ps

module e2q_cordic_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [e2q_pkg::StageW-1:0]    stage,
  input  e2q_pkg::row_t                 row_in,
  output e2q_pkg::row_t                 row_out
);

  e2q_pkg::row_t row_next;

  always_comb begin
    e2q_pkg::q30_t dx;
    e2q_pkg::q30_t dy;
    e2q_pkg::q30_t ang;
    row_next = row_in;
    ang = e2q_pkg::atan_units(stage);
    for (int l = 0; l < e2q_pkg::LaneCount; l++) begin
      dx = row_in.rot[l].y >>> stage;
      dy = row_in.rot[l].x >>> stage;
      // A residual angle of zero rotates in the positive direction.
      if (!row_in.rot[l].z[31]) begin
        row_next.rot[l].x = row_in.rot[l].x - dx;
        row_next.rot[l].y = row_in.rot[l].y + dy;
        row_next.rot[l].z = row_in.rot[l].z - ang;
      end else begin
        row_next.rot[l].x = row_in.rot[l].x + dx;
        row_next.rot[l].y = row_in.rot[l].y - dy;
        row_next.rot[l].z = row_in.rot[l].z + ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_out.valid <= 1'b0;
    end else if (en) begin
      row_out <= row_next;
    end
  end

endmodule

// File: rtl/e2q_prod.sv
`timescale 1ns / 1ps

module e2q_prod (
  input  logic                 clk,
  input  logic                 en,
  input  e2q_pkg::q30_t        a,
  input  e2q_pkg::q30_t        b,
  output logic signed [15:0]   r
);

  logic signed [63:0] prod;
  logic signed [63:0] rounded;
  logic signed [18:0] scaled;
  logic signed [15:0] r_next;

  always_comb begin
    rounded = prod + 64'sh0000_1000_0000_0000;
    scaled  = rounded[63:45];
    if (scaled > 19'sd32767) begin
      r_next = 16'sd32767;
    end else if (scaled < -19'sd32768) begin
      r_next = -16'sd32768;
    end else begin
      r_next = scaled[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
      r    <= r_next;
    end
  end

endmodule

// File: tb/quaternion_checker.sv
`timescale 1ns / 1ps

module quaternion_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] angle_first,
  input  logic signed [15:0] angle_second,
  input  logic signed [15:0] angle_third,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] q_w,
  input  logic signed [15:0] q_x,
  input  logic signed [15:0] q_y,
  input  logic signed [15:0] q_z,
  output int                 fail_count,
  output int                 quats_pending
);

  localparam int StageCount = (e2q_pkg::TrigStages > 24) ? 24 :
                              ((e2q_pkg::TrigStages < 0) ? 0 : e2q_pkg::TrigStages);
  localparam longint RotatorGain = 64'sd652032874;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  quat_t quat_queue[$];

  // Arctangent of 2^-i, 2^32 units per full turn.
  function automatic longint atan_step(input int i);
    case (i)
      0:       return 64'sh20000000;
      1:       return 64'sh12E4051E;
      2:       return 64'sh09FB385B;
      3:       return 64'sh051111D4;
      4:       return 64'sh028B0D43;
      5:       return 64'sh0145D7E1;
      6:       return 64'sh00A2F61E;
      7:       return 64'sh00517C55;
      8:       return 64'sh0028BE53;
      9:       return 64'sh00145F2F;
      10:      return 64'sh000A2F98;
      11:      return 64'sh000517CC;
      12:      return 64'sh00028BE6;
      13:      return 64'sh000145F3;
      14:      return 64'sh0000A2F9;
      15:      return 64'sh0000517C;
      16:      return 64'sh000028BE;
      17:      return 64'sh0000145F;
      18:      return 64'sh00000A2F;
      19:      return 64'sh00000517;
      20:      return 64'sh0000028B;
      21:      return 64'sh00000145;
      22:      return 64'sh000000A2;
      23:      return 64'sh00000051;
      default: return 64'sh0;
    endcase
  endfunction

  // The 17-bit half angle has 2^17 units per turn; cosine and sine come back in Q30.
  function automatic void half_angle_trig(input logic signed [16:0] half,
                                          output longint cs, output longint sn);
    logic [31:0] ang;
    logic        flip;
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    ang = {half, 15'b0};
    // Angles in the left half plane are turned by pi and the results negated.
    flip = ang[31] ^ ang[30];
    if (flip) ang[31] = ~ang[31];
    z = $signed(ang);
    x = RotatorGain;
    y = 0;
    for (int i = 0; i < StageCount; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_step(i);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_step(i);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cs = x;
    sn = y;
  endfunction

  function automatic logic signed [15:0] q15_product(input longint p, input longint q);
    longint r;
    r = (p * q + (64'sd1 <<< 44)) >>> 45;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic quat_t euler_quat(input logic signed [15:0] a,
                                       input logic signed [15:0] b,
                                       input logic signed [15:0] c);
    logic signed [16:0] sum_half;
    logic signed [16:0] diff_half;
    logic signed [16:0] mid_half;
    longint             cs;
    longint             ss;
    longint             cd;
    longint             sd;
    longint             cb;
    longint             sb;
    quat_t              q;
    sum_half = a + c;
    diff_half = a - c;
    mid_half = b;
    half_angle_trig(sum_half, cs, ss);
    half_angle_trig(diff_half, cd, sd);
    half_angle_trig(mid_half, cb, sb);
    q.w = q15_product(cs, cb);
    q.x = q15_product(cd, sb);
    q.y = q15_product(sd, sb);
    q.z = q15_product(ss, cb);
    return q;
  endfunction

  task automatic check_part(input string part, input logic signed [15:0] want,
                            input logic signed [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, part, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    quat_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (quat_queue.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual w=%0d x=%0d y=%0d z=%0d",
                   $time, q_w, q_x, q_y, q_z);
          fail_count++;
        end else begin
          want = quat_queue.pop_front();
          check_part("q_w", want.w, q_w);
          check_part("q_x", want.x, q_x);
          check_part("q_y", want.y, q_y);
          check_part("q_z", want.z, q_z);
        end
      end
      if (in_valid && !in_stall)
        quat_queue.push_back(euler_quat(angle_first, angle_second, angle_third));
      quats_pending = quat_queue.size();
    end
  end

endmodule

// File: tb/euler_to_quaternion_tb.sv
`timescale 1ns / 1ps

module euler_to_quaternion_tb;

  localparam int RandomWords = 700;
  localparam int WatchdogLimit = 2000;
  localparam int TailCycles = 40;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] angle_first = '0;
  logic signed [15:0] angle_second = '0;
  logic signed [15:0] angle_third = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] q_w;
  logic signed [15:0] q_x;
  logic signed [15:0] q_y;
  logic signed [15:0] q_z;

  int fail_count;
  int quats_pending;
  int idle_cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  always #1 clk = ~clk;

  euler_to_quaternion dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .angle_first  (angle_first),
    .angle_second (angle_second),
    .angle_third  (angle_third),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .q_w          (q_w),
    .q_x          (q_x),
    .q_y          (q_y),
    .q_z          (q_z)
  );

  quaternion_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .angle_first   (angle_first),
    .angle_second  (angle_second),
    .angle_third   (angle_third),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .q_w           (q_w),
    .q_x           (q_x),
    .q_y           (q_y),
    .q_z           (q_z),
    .fail_count    (fail_count),
    .quats_pending (quats_pending)
  );

  // The receiver switches between free flow, random, heavy and periodic stalling.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(5, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 1) == 1);
      end
      2: begin
        out_stall <= ($urandom_range(0, 7) != 0);
      end
      default: begin
        out_stall <= stall_left[2];
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("euler_to_quaternion test failed");
        $finish;
      end
    end
  end

  // Sends one word inside a burst, opening a new burst after a random gap when one runs out.
  task automatic push_word(input logic signed [15:0] a, input logic signed [15:0] b,
                           input logic signed [15:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    angle_first <= a;
    angle_second <= b;
    angle_third <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (quats_pending != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_angle();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return $signed(16'($urandom_range(0, 65535)));
    if (sel < 75) begin
      case ($urandom_range(0, 8))
        0:       return -16'sd32768;
        1:       return -16'sd32767;
        2:       return -16'sd1;
        3:       return 16'sd0;
        4:       return 16'sd1;
        5:       return 16'sd32767;
        6:       return 16'sd32766;
        7:       return 16'sd16384;
        default: return -16'sd16384;
      endcase
    end
    if (sel < 90) return $signed(16'($urandom_range(0, 511))) - 16'sd256;
    // Near the quarter turns, where a sum or difference of two such angles meets the half-plane fold.
    return ($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384)
           + $signed(16'($urandom_range(0, 63))) - 16'sd32;
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push_word(16'sd0, 16'sd0, 16'sd0);
    push_word(16'sd32767, 16'sd32767, 16'sd32767);
    push_word(-16'sd32768, -16'sd32768, -16'sd32768);
    push_word(16'sd32767, -16'sd32768, 16'sd32767);
    push_word(-16'sd32768, 16'sd32767, -16'sd32768);
    push_word(16'sd16384, 16'sd16384, 16'sd16384);
    push_word(-16'sd16384, -16'sd16384, -16'sd16384);
    // Sums on either side of the quarter turns.
    push_word(16'sd16384, 16'sd0, 16'sd16384);
    push_word(16'sd16383, 16'sd0, 16'sd16384);
    push_word(-16'sd16384, 16'sd0, -16'sd16384);
    push_word(-16'sd16384, 16'sd0, -16'sd16385);
    // Differences at the ends of the 17-bit range.
    push_word(16'sd32767, 16'sd0, -16'sd32768);
    push_word(-16'sd32768, 16'sd0, 16'sd32767);
    push_word(16'sd0, 16'sd32767, 16'sd0);
    push_word(16'sd0, -16'sd32768, 16'sd0);
    push_word(16'sd0, 16'sd16384, 16'sd0);
    push_word(16'sd1, -16'sd1, 16'sd1);
    push_word(-16'sd1, 16'sd1, -16'sd1);
    push_word(16'sd8192, 16'sd8192, -16'sd8192);
    push_word(16'sd21845, -16'sd21846, 16'sd21845);
    drain_results();

    for (int n = 0; n < RandomWords; n++) begin
      if (n == RandomWords / 2) drain_results();
      push_word(pick_angle(), pick_angle(), pick_angle());
    end

    drain_results();
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0)
      $display("euler_to_quaternion test passed");
    else
      $display("euler_to_quaternion test failed");
    $finish;
  end

endmodule
